// ===== design/cfe_pkg.sv =====
// Shared types, constants and the CRC16 byte update for the command frame encoder.
`default_nettype none

package cfe_pkg;

   localparam logic [7:0]  MAX_PAYLOAD = 8'd254;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   localparam logic [7:0] HEAD_RESET = 8'd165;
   localparam logic [7:0] TAIL_RESET = 8'd90;

   // Opcodes of an input item
   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   // Register indexes on the configuration port
   localparam logic CSR_HEAD = 1'b0;
   localparam logic CSR_TAIL = 1'b1;

   localparam int MAX_RESULTS = 6;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       run_last;
      logic       sequence_error;
   } result_type;

   typedef result_type [MAX_RESULTS-1:0] result_set_type;

   typedef struct packed {
      result_set_type       results;
      logic [COUNT_W-1:0]   count;
   } frame_load_type;

   // Reflected CRC16 update over one byte, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/crc16_command_frame_encoder.sv =====
// Top level of the command frame encoder: CSR port, frame builder and result queue.
`default_nettype none

// Command frame encoder. Each input item is turned into the bytes of an
// outgoing frame: head, length (1 + payload length, saturated at MAX_PAYLOAD,
// 254 by default), command, payload, Modbus CRC16 low then high byte, tail. A start
// item (opcode 0) yields 3 bytes, or 6 when its payload length is zero; a
// payload item (opcode 1) yields 1 byte, or 4 when it is the last declared
// byte. A payload byte with no frame open yields a single result with
// sequence_error set and leaves the frame state alone; a start during an
// open frame drops that frame without CRC or tail. rsp_run_last marks the
// final result of each item. Rate: the item's work is done in the cycle it
// is accepted, and its results then leave at one per output transfer. The
// next item is taken in the same cycle as the final result of the previous
// one transfers, so single-result items flow at one per clock while the
// output is not stalled. head_byte sits at address 0 and tail_byte at
// address 4; write them only while idle.
module crc16_command_frame_encoder #(
   parameter logic [7:0] MAX_PAYLOAD = cfe_pkg::MAX_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_command_code,
   input  wire logic [7:0]  req_payload_length,
   input  wire logic [7:0]  req_data_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_frame_end,
   output logic             rsp_run_last,
   output logic             rsp_sequence_error,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0]               head_byte_ff;
   logic [7:0]               tail_byte_ff;
   logic                     csr_write;
   logic                     csr_index;

   logic                     queue_free;
   logic                     req_accept;
   cfe_pkg::frame_load_type  frame_load;
   cfe_pkg::result_type      rsp_result;

   // Configuration registers: word address selects the register
   always_comb begin
      csr_pready = 1'b1;
      csr_index  = csr_paddr[2];
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      case (csr_index)
         cfe_pkg::CSR_HEAD: csr_prdata = {24'd0, head_byte_ff};
         cfe_pkg::CSR_TAIL: csr_prdata = {24'd0, tail_byte_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_byte_ff <= cfe_pkg::HEAD_RESET;
         tail_byte_ff <= cfe_pkg::TAIL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            cfe_pkg::CSR_HEAD: head_byte_ff <= csr_pwdata[7:0];
            cfe_pkg::CSR_TAIL: tail_byte_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Hold the input until the queue can take the next result set
   always_comb begin
      req_stall  = !queue_free;
      req_accept = req_valid && queue_free;
   end

   cfe_frame_builder #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_builder (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .opcode         (req_opcode),
      .command_code   (req_command_code),
      .payload_length (req_payload_length),
      .data_byte      (req_data_byte),
      .head_byte      (head_byte_ff),
      .tail_byte      (tail_byte_ff),
      .frame_load     (frame_load)
   );

   cfe_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .frame_load (frame_load),
      .free       (queue_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // Unpack the current result onto the output ports
   always_comb begin
      rsp_tx_byte        = rsp_result.tx_byte;
      rsp_frame_end      = rsp_result.frame_end;
      rsp_run_last       = rsp_result.run_last;
      rsp_sequence_error = rsp_result.sequence_error;
   end

endmodule

`default_nettype wire

// ===== design/cfe_frame_builder.sv =====
// Frame state and the result set that one input item produces.
`default_nettype none

module cfe_frame_builder #(
   parameter logic [7:0] MAX_PAYLOAD = cfe_pkg::MAX_PAYLOAD
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  opcode,
   input  wire logic [7:0]            command_code,
   input  wire logic [7:0]            payload_length,
   input  wire logic [7:0]            data_byte,
   input  wire logic [7:0]            head_byte,
   input  wire logic [7:0]            tail_byte,
   output cfe_pkg::frame_load_type    frame_load
);

   logic [15:0] running_crc_ff, running_crc_in;
   logic [7:0]  bytes_remaining_ff, bytes_remaining_in;
   logic        frame_open_ff, frame_open_in;

   logic [7:0]  plen_sat;
   logic [7:0]  len_byte;
   logic [15:0] crc_len;
   logic [15:0] crc_cmd;
   logic [15:0] crc_data;
   logic [7:0]  remaining_dec;

   function automatic cfe_pkg::result_type mk(input logic [7:0] b, input logic e,
                                              input logic l, input logic r);
      cfe_pkg::result_type res;
      res.tx_byte        = b;
      res.frame_end      = e;
      res.run_last       = l;
      res.sequence_error = r;
      return res;
   endfunction

   always_comb begin
      plen_sat      = (payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_length;
      len_byte      = plen_sat + 8'd1;
      crc_len       = cfe_pkg::crc_byte(cfe_pkg::CRC_INIT, len_byte);
      crc_cmd       = cfe_pkg::crc_byte(crc_len, command_code);
      crc_data      = cfe_pkg::crc_byte(running_crc_ff, data_byte);
      remaining_dec = bytes_remaining_ff - 8'd1;
   end

   always_comb begin
      frame_load         = '0;
      running_crc_in     = running_crc_ff;
      bytes_remaining_in = bytes_remaining_ff;
      frame_open_in      = frame_open_ff;
      if (opcode == cfe_pkg::OP_START) begin
         frame_load.results[0] = mk(head_byte, 1'b0, 1'b0, 1'b0);
         frame_load.results[1] = mk(len_byte, 1'b0, 1'b0, 1'b0);
         if (plen_sat == 8'd0) begin
            // Empty payload: close the frame in the same item
            frame_load.results[2] = mk(command_code, 1'b0, 1'b0, 1'b0);
            frame_load.results[3] = mk(crc_cmd[7:0], 1'b0, 1'b0, 1'b0);
            frame_load.results[4] = mk(crc_cmd[15:8], 1'b0, 1'b0, 1'b0);
            frame_load.results[5] = mk(tail_byte, 1'b1, 1'b1, 1'b0);
            frame_load.count      = cfe_pkg::COUNT_W'(6);
            running_crc_in        = cfe_pkg::CRC_INIT;
            bytes_remaining_in    = 8'd0;
            frame_open_in         = 1'b0;
         end else begin
            frame_load.results[2] = mk(command_code, 1'b0, 1'b1, 1'b0);
            frame_load.count      = cfe_pkg::COUNT_W'(3);
            running_crc_in        = crc_cmd;
            bytes_remaining_in    = plen_sat;
            frame_open_in         = 1'b1;
         end
      end else if (!frame_open_ff || bytes_remaining_ff == 8'd0) begin
         frame_load.results[0] = mk(8'd0, 1'b0, 1'b1, 1'b1);
         frame_load.count      = cfe_pkg::COUNT_W'(1);
      end else if (remaining_dec == 8'd0) begin
         frame_load.results[0] = mk(data_byte, 1'b0, 1'b0, 1'b0);
         frame_load.results[1] = mk(crc_data[7:0], 1'b0, 1'b0, 1'b0);
         frame_load.results[2] = mk(crc_data[15:8], 1'b0, 1'b0, 1'b0);
         frame_load.results[3] = mk(tail_byte, 1'b1, 1'b1, 1'b0);
         frame_load.count      = cfe_pkg::COUNT_W'(4);
         running_crc_in        = cfe_pkg::CRC_INIT;
         bytes_remaining_in    = 8'd0;
         frame_open_in         = 1'b0;
      end else begin
         frame_load.results[0] = mk(data_byte, 1'b0, 1'b1, 1'b0);
         frame_load.count      = cfe_pkg::COUNT_W'(1);
         running_crc_in        = crc_data;
         bytes_remaining_in    = remaining_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff     <= cfe_pkg::CRC_INIT;
         bytes_remaining_ff <= 8'd0;
         frame_open_ff      <= 1'b0;
      end else if (accept) begin
         running_crc_ff     <= running_crc_in;
         bytes_remaining_ff <= bytes_remaining_in;
         frame_open_ff      <= frame_open_in;
      end
   end

   closed_frame_is_clean: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> (bytes_remaining_ff == 8'd0 && running_crc_ff == cfe_pkg::CRC_INIT))
      else $error("closed frame left state behind");

endmodule

`default_nettype wire

// ===== design/cfe_result_queue.sv =====
// Result register bank that delivers one result of an item per transfer.
`default_nettype none

module cfe_result_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire cfe_pkg::frame_load_type frame_load,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output cfe_pkg::result_type        rsp_result
);

   cfe_pkg::result_set_type          entries_ff;
   logic [cfe_pkg::COUNT_W-1:0]      count_ff;
   logic [cfe_pkg::IDX_W-1:0]        index_ff;
   logic                             pop;
   logic                             at_last;

   always_comb begin
      rsp_valid  = (count_ff != '0);
      rsp_result = entries_ff[index_ff];
      pop        = rsp_valid && !rsp_stall;
      at_last    = (index_ff == cfe_pkg::IDX_W'(count_ff - cfe_pkg::COUNT_W'(1)));
      free       = !rsp_valid || (pop && at_last);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entries_ff <= frame_load.results;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= '0;
      end else if (load) begin
         count_ff <= frame_load.count;
         index_ff <= '0;
      end else if (pop) begin
         if (at_last) begin
            count_ff <= '0;
            index_ff <= '0;
         end else begin
            index_ff <= index_ff + cfe_pkg::IDX_W'(1);
         end
      end
   end

   no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("results loaded over undelivered results");

   index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cfe_pkg::COUNT_W'(index_ff) < count_ff))
      else $error("result index beyond loaded count");

   last_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result.run_last == at_last))
      else $error("run_last not on final result of item");

   load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded item produced no result");

endmodule

`default_nettype wire
